// ----- src/rccbc_pkg.sv -----
// shared types and constants for the cartridge command bank controller
package rccbc_pkg;

  typedef enum logic [1:0] {
    OP_BUTTON = 2'd0,
    OP_WRITE  = 2'd1,
    OP_READ   = 2'd2,
    OP_TICK   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    SRC_PASS     = 2'd0,
    SRC_CART     = 2'd1,
    SRC_INTERNAL = 2'd2,
    SRC_INVALID  = 2'd3
  } src_e;

  typedef enum logic [2:0] {
    MODE_DISABLED  = 3'd0,
    MODE_LOCKED    = 3'd1,
    MODE_WAITING   = 3'd2,
    MODE_RECEIVING = 3'd3,
    MODE_PENDING   = 3'd4
  } mode_e;

  // cpu addresses of the command port registers
  localparam logic [15:0] ADDR_CONFIRM  = 16'd0;
  localparam logic [15:0] ADDR_COMMAND  = 16'd1;
  localparam logic [15:0] ADDR_DATA_ONE = 16'd2;
  localparam logic [15:0] ADDR_DATA_TWO = 16'd3;
  localparam logic [15:0] ROM_AREA      = 16'd16384;

  localparam logic [7:0] CMD_BANK_FIRST = 8'd1;
  localparam logic [7:0] CMD_BANK_LAST  = 8'd33;
  localparam logic [7:0] CMD_INTERNAL   = 8'd34;
  localparam logic [7:0] CMD_RESET      = 8'd36;
  localparam logic [7:0] CMD_EXTENDED   = 8'd40;
  localparam logic [7:0] CMD_LOCK       = 8'd46;

  localparam logic [7:0] LOCK_KEY_LOCK    = 8'd1;
  localparam logic [7:0] LOCK_KEY_UNLOCK  = 8'd16;
  localparam logic [7:0] LOCK_KEY_DISABLE = 8'd31;

  localparam logic [7:0] INTERNAL_BANK = 8'd32;

  localparam logic [6:0] DELAY_CONFIRM = 7'd35;
  localparam logic [6:0] DELAY_48K     = 7'd119;
  localparam logic [6:0] DELAY_128K    = 7'd121;

  typedef struct packed {
    logic [1:0]  operation;
    logic [15:0] address;
    logic [7:0]  write_data;
    logic [7:0]  tick_tstates;
  } rccbc_in_t;

  typedef struct packed {
    logic [1:0]  read_source;
    logic [18:0] cart_address;
    logic        cpu_reset;
    logic        cpu_nmi;
    logic [2:0]  mode;
    logic [7:0]  active_bank;
  } rccbc_out_t;

  // controller results for one transaction
  typedef struct packed {
    logic       cpu_reset;
    logic       cpu_nmi;
    logic [2:0] mode;
    logic [7:0] active_bank;
  } rccbc_ctrl_t;

  // read mapping results
  typedef struct packed {
    logic [1:0]  read_source;
    logic [18:0] cart_address;
  } rccbc_map_t;

endpackage

// ----- src/rccbc_map.sv -----
// read mapping of rom-area accesses onto cartridge banks
module rccbc_map import rccbc_pkg::*; #(
  parameter int BANK_BYTES = 16384,
  parameter int NUM_BANKS  = 32
) (
  input  rccbc_in_t  item_i,
  input  logic       switched_on_i,
  input  logic [7:0] bank_i,
  output rccbc_map_t map_o
);

  logic [18:0] cart_addr;

  // byte address wraps at 19 bits
  assign cart_addr = 19'(bank_i) * 19'(BANK_BYTES) + 19'(item_i.address);

  always_comb begin
    map_o.read_source  = SRC_PASS;
    map_o.cart_address = '0;
    if (op_e'(item_i.operation) == OP_READ && switched_on_i && item_i.address < ROM_AREA) begin
      if (bank_i == INTERNAL_BANK) begin
        map_o.read_source = SRC_INTERNAL;
      end else if (bank_i < 8'(NUM_BANKS)) begin
        map_o.read_source  = SRC_CART;
        map_o.cart_address = cart_addr;
      end else begin
        map_o.read_source = SRC_INVALID;
      end
    end
  end

endmodule

// ----- src/rccbc_ctrl.sv -----
// command decoder, delay timer and bank/mode state of the controller
module rccbc_ctrl import rccbc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  input  logic        fire_i,
  input  rccbc_in_t   item_i,
  output logic        switched_on_o,
  output logic [7:0]  bank_o,
  output rccbc_ctrl_t res_o
);

  logic        is_48k_q;
  mode_e       mode_q, mode_d;
  logic        sw_q, sw_d;
  logic [7:0]  bank_q, bank_d;
  logic [7:0]  cmd_q, cmd_d;
  logic [7:0]  d1_q, d1_d;
  logic [7:0]  d2_q, d2_d;
  logic [7:0]  pc_q, pc_d;
  logic [6:0]  dly_q, dly_d;
  logic [15:0] el_q, el_d;
  logic        cfl_q, cfl_d;
  logic        rst_pulse, nmi_pulse;
  logic [16:0] el_sum;
  logic [7:0]  wd;

  // lock command: matching data bytes pick the new mode
  function automatic mode_e apply_lock(mode_e cur, logic [7:0] a, logic [7:0] b);
    mode_e m;
    m = cur;
    if (a == b) begin
      case (a)
        LOCK_KEY_LOCK:    m = MODE_LOCKED;
        LOCK_KEY_UNLOCK:  m = MODE_WAITING;
        LOCK_KEY_DISABLE: m = MODE_DISABLED;
        default:          m = cur;
      endcase
    end
    return m;
  endfunction

  assign wd     = item_i.write_data;
  assign el_sum = {1'b0, el_q} + 17'(item_i.tick_tstates);

  always_comb begin
    mode_d    = mode_q;
    sw_d      = sw_q;
    bank_d    = bank_q;
    cmd_d     = cmd_q;
    d1_d      = d1_q;
    d2_d      = d2_q;
    pc_d      = pc_q;
    dly_d     = dly_q;
    el_d      = el_q;
    cfl_d     = cfl_q;
    rst_pulse = 1'b0;
    nmi_pulse = 1'b0;
    case (op_e'(item_i.operation))
      OP_BUTTON: begin
        sw_d      = 1'b1;
        bank_d    = '0;
        mode_d    = MODE_WAITING;
        cfl_d     = 1'b0;
        rst_pulse = 1'b1;
      end
      OP_WRITE: begin
        if (sw_q && item_i.address < ROM_AREA && mode_q != MODE_DISABLED) begin
          case (item_i.address)
            ADDR_CONFIRM: begin
              mode_d = MODE_PENDING;
              dly_d  = DELAY_CONFIRM;
              el_d   = '0;
              cfl_d  = (mode_q == MODE_LOCKED) || (mode_q == MODE_PENDING && cfl_q);
            end
            ADDR_COMMAND: begin
              if (mode_d == MODE_WAITING) begin
                pc_d   = '0;
                cmd_d  = wd;
                mode_d = MODE_RECEIVING;
              end
              if (mode_d == MODE_RECEIVING) begin
                pc_d = pc_d + 8'd1;
                // simple command complete once its value matches the write count
                if (wd < CMD_EXTENDED && wd == pc_d) begin
                  mode_d = MODE_PENDING;
                  dly_d  = is_48k_q ? DELAY_48K : DELAY_128K;
                  el_d   = '0;
                  cfl_d  = 1'b0;
                end else if (wd != cmd_d) begin
                  pc_d  = 8'd1;
                  cmd_d = wd;
                end
              end
            end
            ADDR_DATA_ONE: d1_d = wd;
            ADDR_DATA_TWO: d2_d = wd;
            default: ;
          endcase
        end
      end
      OP_TICK: begin
        el_d = el_sum[16] ? 16'hFFFF : el_sum[15:0];
        if (mode_q == MODE_PENDING && el_d > {9'd0, dly_q}) begin
          if (cfl_q) begin
            // scheduled while locked: only the lock command may act
            mode_d = MODE_LOCKED;
            if (cmd_q == CMD_LOCK) begin
              mode_d = apply_lock(MODE_LOCKED, d1_q, d2_q);
            end
            cfl_d = 1'b0;
          end else begin
            if (cmd_q inside {[CMD_BANK_FIRST:CMD_BANK_LAST]}) begin
              bank_d = cmd_q - 8'd1;
            end else if (cmd_q == CMD_INTERNAL) begin
              mode_d = MODE_LOCKED;
              bank_d = INTERNAL_BANK;
            end else if (cmd_q == CMD_RESET) begin
              rst_pulse = 1'b1;
            end else if (cmd_q == CMD_EXTENDED) begin
              bank_d = d1_q - 8'd1;
              if (d2_q[3]) mode_d = MODE_DISABLED;
              if (d2_q[2]) mode_d = MODE_LOCKED;
              nmi_pulse = d2_q[1];
              rst_pulse = d2_q[0];
            end else if (cmd_q == CMD_LOCK) begin
              mode_d = apply_lock(mode_d, d1_q, d2_q);
            end
            if (mode_d == MODE_PENDING) mode_d = MODE_WAITING;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      is_48k_q <= 1'b1;
    end else if (cfg_we_i) begin
      is_48k_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_DISABLED;
      sw_q   <= 1'b0;
      bank_q <= '0;
      cmd_q  <= '0;
      d1_q   <= '0;
      d2_q   <= '0;
      pc_q   <= '0;
      dly_q  <= '0;
      el_q   <= '0;
      cfl_q  <= 1'b0;
    end else if (fire_i) begin
      mode_q <= mode_d;
      sw_q   <= sw_d;
      bank_q <= bank_d;
      cmd_q  <= cmd_d;
      d1_q   <= d1_d;
      d2_q   <= d2_d;
      pc_q   <= pc_d;
      dly_q  <= dly_d;
      el_q   <= el_d;
      cfl_q  <= cfl_d;
    end
  end

  assign switched_on_o     = sw_q;
  assign bank_o            = bank_q;
  assign res_o.cpu_reset   = rst_pulse;
  assign res_o.cpu_nmi     = nmi_pulse;
  assign res_o.mode        = mode_d;
  assign res_o.active_bank = bank_d;

  a_nmi_from_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && res_o.cpu_nmi) |-> (op_e'(item_i.operation) == OP_TICK))
    else $error("nmi pulse outside an instruction tick");

  a_locked_flag_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfl_q |-> (mode_q == MODE_PENDING))
    else $error("locked-origin flag set while not pending");

  a_pending_delay: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == MODE_PENDING) |->
      (dly_q == DELAY_CONFIRM || dly_q == DELAY_48K || dly_q == DELAY_128K))
    else $error("pending command with unexpected delay");

  a_no_change_when_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && !sw_q && op_e'(item_i.operation) == OP_WRITE) |=>
      ($stable(mode_q) && $stable(bank_q)))
    else $error("write changed state before switch-on");

endmodule

// ----- src/rom_cartridge_command_bank_controller_top.sv -----
// top level of the rom cartridge command bank controller
// Each transaction (button press, memory write, memory read or instruction tick) gives one
// result. An accepted transaction is held in an input register, processed in one pass of
// decode and state update, and its result is captured in an output register, so while the
// output is not stalled a new transaction is taken every cycle; each result passes through
// the input register and then the output register before it is offered. A stalled output
// holds the result and, once the input register is also full, holds off the input.
// The rate is one transaction per cycle while the output is not stalled. The machine_is_48k
// register (cfg_we_i / cfg_wdata_i) picks the delay of simple commands and should be
// written only while no transaction is in flight.
module rom_cartridge_command_bank_controller_top import rccbc_pkg::*; #(
  parameter int BANK_BYTES = 16384,
  parameter int NUM_BANKS  = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  rccbc_in_t  in_data_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output rccbc_out_t out_data_o
);

  logic        in_valid_q;
  rccbc_in_t   in_q;
  logic        out_valid_q;
  rccbc_out_t  out_q;
  logic        fire;
  logic        sw;
  logic [7:0]  bank;
  rccbc_ctrl_t ctrl_res;
  rccbc_map_t  map_res;

  // process the held transaction when the result register can take it
  assign fire       = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) in_valid_q <= in_valid_i;
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) in_q <= in_data_i;
    if (fire) begin
      out_q.read_source  <= map_res.read_source;
      out_q.cart_address <= map_res.cart_address;
      out_q.cpu_reset    <= ctrl_res.cpu_reset;
      out_q.cpu_nmi      <= ctrl_res.cpu_nmi;
      out_q.mode         <= ctrl_res.mode;
      out_q.active_bank  <= ctrl_res.active_bank;
    end
  end

  rccbc_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .fire_i        (fire),
    .item_i        (in_q),
    .switched_on_o (sw),
    .bank_o        (bank),
    .res_o         (ctrl_res)
  );

  rccbc_map #(
    .BANK_BYTES (BANK_BYTES),
    .NUM_BANKS  (NUM_BANKS)
  ) u_map (
    .item_i        (in_q),
    .switched_on_i (sw),
    .bank_i        (bank),
    .map_o         (map_res)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ----- bench/rom_cartridge_command_bank_controller_top_test.sv -----
// self-checking testbench for the rom cartridge command bank controller top level
module rom_cartridge_command_bank_controller_top_test;
  import rccbc_pkg::*;

  localparam int BANK_BYTES  = 16384;
  localparam int NUM_BANKS   = 32;
  localparam int QUIET_LIMIT = 1000;
  localparam int MAX_PRINTED = 50;

  // control bits of the extended command, taken from the second data byte
  localparam int EXT_RESET_BIT   = 0;
  localparam int EXT_NMI_BIT     = 1;
  localparam int EXT_LOCK_BIT    = 2;
  localparam int EXT_DISABLE_BIT = 3;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       cfg_we_i    = 1'b0;
  logic       cfg_wdata_i = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic       in_ready_o;
  rccbc_in_t  in_data_i   = '0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  rccbc_out_t out_data_o;

  rom_cartridge_command_bank_controller_top #(
    .BANK_BYTES(BANK_BYTES),
    .NUM_BANKS (NUM_BANKS)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // controller state as the block should hold it
  logic        cfg_48k        = 1'b1;
  mode_e       st_mode        = MODE_DISABLED;
  logic        st_powered     = 1'b0;
  logic [7:0]  st_bank        = '0;
  logic [7:0]  st_cmd         = '0;
  logic [7:0]  st_d1          = '0;
  logic [7:0]  st_d2          = '0;
  logic [7:0]  st_pulses      = '0;
  logic [6:0]  st_delay       = '0;
  logic [15:0] st_elapsed     = '0;
  logic        st_from_locked = 1'b0;

  rccbc_out_t  expected_results[$];
  int unsigned items_sent      = 0;
  int unsigned results_checked = 0;
  int unsigned commands_run    = 0;
  int unsigned mismatches      = 0;
  int unsigned recv_wait       = 0;
  int unsigned quiet_cycles    = 0;
  bit          send_idle       = 1'b1;
  bit          recv_idle       = 1'b1;

  function automatic void arm_command(input logic [6:0] delay, input logic locked_origin);
    st_mode        = MODE_PENDING;
    st_delay       = delay;
    st_elapsed     = '0;
    st_from_locked = locked_origin;
  endfunction

  function automatic void apply_lock_key();
    if (st_d1 == st_d2) begin
      if (st_d1 == LOCK_KEY_LOCK) st_mode = MODE_LOCKED;
      else if (st_d1 == LOCK_KEY_UNLOCK) st_mode = MODE_WAITING;
      else if (st_d1 == LOCK_KEY_DISABLE) st_mode = MODE_DISABLED;
    end
  endfunction

  // advances the predicted state by one transaction and returns its result
  function automatic rccbc_out_t cart_predict(input rccbc_in_t item);
    rccbc_out_t  res;
    logic [16:0] sum;
    logic [7:0]  code;
    res = '0;
    case (op_e'(item.operation))
      OP_BUTTON: begin
        st_powered     = 1'b1;
        st_bank        = '0;
        st_mode        = MODE_WAITING;
        st_from_locked = 1'b0;
        res.cpu_reset  = 1'b1;
      end
      OP_WRITE: begin
        if (st_powered && item.address < ROM_AREA && st_mode != MODE_DISABLED) begin
          case (item.address)
            ADDR_CONFIRM: arm_command(DELAY_CONFIRM, st_mode == MODE_LOCKED ||
                                      (st_mode == MODE_PENDING && st_from_locked));
            ADDR_COMMAND: begin
              if (st_mode == MODE_WAITING) begin
                st_pulses = '0;
                st_cmd    = item.write_data;
                st_mode   = MODE_RECEIVING;
              end
              if (st_mode == MODE_RECEIVING) begin
                st_pulses = st_pulses + 8'd1;
                if (item.write_data < CMD_EXTENDED && item.write_data == st_pulses) begin
                  arm_command(cfg_48k ? DELAY_48K : DELAY_128K, 1'b0);
                end else if (item.write_data != st_cmd) begin
                  st_pulses = 8'd1;
                  st_cmd    = item.write_data;
                end
              end
            end
            ADDR_DATA_ONE: st_d1 = item.write_data;
            ADDR_DATA_TWO: st_d2 = item.write_data;
            default: ;
          endcase
        end
      end
      OP_READ: begin
        if (st_powered && item.address < ROM_AREA) begin
          if (st_bank == INTERNAL_BANK) begin
            res.read_source = SRC_INTERNAL;
          end else if (st_bank < NUM_BANKS) begin
            res.read_source  = SRC_CART;
            res.cart_address = 19'(st_bank * BANK_BYTES + item.address);
          end else begin
            res.read_source = SRC_INVALID;
          end
        end
      end
      OP_TICK: begin
        sum        = {1'b0, st_elapsed} + 17'(item.tick_tstates);
        st_elapsed = sum[16] ? 16'hFFFF : sum[15:0];
        if (st_mode == MODE_PENDING && st_elapsed > 16'(st_delay)) begin
          commands_run++;
          code = st_cmd;
          if (st_from_locked) begin
            // a command confirmed while locked only gets to act if it is the lock command
            st_mode = MODE_LOCKED;
            if (code == CMD_LOCK) apply_lock_key();
            st_from_locked = 1'b0;
          end else begin
            if (code >= CMD_BANK_FIRST && code <= CMD_BANK_LAST) begin
              st_bank = code - 8'd1;
            end else if (code == CMD_INTERNAL) begin
              st_mode = MODE_LOCKED;
              st_bank = INTERNAL_BANK;
            end else if (code == CMD_RESET) begin
              res.cpu_reset = 1'b1;
            end else if (code == CMD_EXTENDED) begin
              st_bank = st_d1 - 8'd1;
              if (st_d2[EXT_DISABLE_BIT]) st_mode = MODE_DISABLED;
              if (st_d2[EXT_LOCK_BIT]) st_mode = MODE_LOCKED;
              if (st_d2[EXT_NMI_BIT]) res.cpu_nmi = 1'b1;
              if (st_d2[EXT_RESET_BIT]) res.cpu_reset = 1'b1;
            end else if (code == CMD_LOCK) begin
              apply_lock_key();
            end
            if (st_mode == MODE_PENDING) st_mode = MODE_WAITING;
          end
        end
      end
      default: ;
    endcase
    res.mode        = st_mode;
    res.active_bank = st_bank;
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatches < MAX_PRINTED) $display("mismatch at result %0d: %s", results_checked, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input int got, input int want);
    if (got != want) report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
  endtask

  // the sender leaves valid high after the transaction; the next call moves it on
  task automatic send_item(input rccbc_in_t item);
    int unsigned gap;
    gap = send_idle ? $urandom_range(0, 13) : 0;
    @(negedge clk_i);
    if (gap != 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    in_data_i  = item;
    do @(posedge clk_i); while (!in_ready_o);
    expected_results.push_back(cart_predict(item));
    items_sent++;
  endtask

  task automatic do_button();
    rccbc_in_t item;
    item              = '0;
    item.operation    = OP_BUTTON;
    item.address      = 16'($urandom);
    item.write_data   = 8'($urandom);
    item.tick_tstates = 8'($urandom);
    send_item(item);
  endtask

  task automatic do_write(input logic [15:0] addr, input logic [7:0] data);
    rccbc_in_t item;
    item              = '0;
    item.operation    = OP_WRITE;
    item.address      = addr;
    item.write_data   = data;
    item.tick_tstates = 8'($urandom);
    send_item(item);
  endtask

  task automatic do_read(input logic [15:0] addr);
    rccbc_in_t item;
    item              = '0;
    item.operation    = OP_READ;
    item.address      = addr;
    item.write_data   = 8'($urandom);
    item.tick_tstates = 8'($urandom);
    send_item(item);
  endtask

  task automatic do_tick(input logic [7:0] tstates);
    rccbc_in_t item;
    item              = '0;
    item.operation    = OP_TICK;
    item.address      = 16'($urandom);
    item.write_data   = 8'($urandom);
    item.tick_tstates = tstates;
    send_item(item);
  endtask

  task automatic drain_results();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (expected_results.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic set_machine_48k(input logic value);
    drain_results();
    cfg_we_i    = 1'b1;
    cfg_wdata_i = value;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    cfg_48k  = value;
  endtask

  task automatic send_noise();
    rccbc_in_t item;
    item.operation    = 2'($urandom_range(0, 3));
    item.address      = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(0, 7)) : 16'($urandom);
    item.write_data   = 8'($urandom);
    item.tick_tstates = 8'($urandom);
    send_item(item);
  endtask

  task automatic send_read_burst();
    int unsigned n;
    n = $urandom_range(1, 4);
    repeat (n) begin
      do_read(($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(0, 16383)));
    end
  endtask

  // ticks until the pending command has run, with the odd read or re-confirm mixed in
  task automatic run_until_done();
    while (st_mode == MODE_PENDING) begin
      case ($urandom_range(0, 19))
        0: do_write(ADDR_CONFIRM, 8'($urandom));
        1, 2: send_read_burst();
        default: do_tick(($urandom_range(0, 2) == 0) ? 8'($urandom) : 8'($urandom_range(0, 40)));
      endcase
    end
  endtask

  task automatic send_simple_command(input logic [7:0] code);
    int k;
    for (k = 0; k < code; k++) begin
      if ($urandom_range(0, 29) == 0) send_noise();
      do_write(ADDR_COMMAND, code);
    end
    run_until_done();
  endtask

  task automatic send_extended_command();
    logic [7:0]  code;
    logic [7:0]  key;
    logic [7:0]  one;
    logic [7:0]  two;
    int unsigned shape;
    shape = $urandom_range(0, 9);
    code  = (shape < 4) ? CMD_EXTENDED : (shape < 8) ? CMD_LOCK : 8'($urandom_range(40, 255));
    if (code == CMD_LOCK) begin
      case ($urandom_range(0, 2))
        0: key = LOCK_KEY_LOCK;
        1: key = LOCK_KEY_UNLOCK;
        default: key = LOCK_KEY_DISABLE;
      endcase
      one = ($urandom_range(0, 5) == 0) ? 8'($urandom) : key;
      two = ($urandom_range(0, 4) == 0) ? 8'($urandom) : key;
    end else begin
      one = ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'($urandom_range(1, 34));
      two = ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'($urandom_range(0, 15));
    end
    do_write(ADDR_COMMAND, code);
    if ($urandom_range(0, 1) == 0) begin
      do_write(ADDR_DATA_ONE, one);
      do_write(ADDR_DATA_TWO, two);
    end else begin
      do_write(ADDR_DATA_TWO, two);
      do_write(ADDR_DATA_ONE, one);
    end
    do_write(ADDR_CONFIRM, 8'($urandom));
    if ($urandom_range(0, 5) == 0) do_write(ADDR_CONFIRM, 8'($urandom));
    run_until_done();
  endtask

  task automatic test_before_power_up();
    do_read(16'd0);
    do_write(ADDR_COMMAND, 8'd1);
    do_tick(8'd0);
  endtask

  task automatic test_address_window();
    do_button();
    do_read(ROM_AREA);
    do_read(ROM_AREA - 16'd1);
    do_write(16'hFFFF, 8'hFF);
  endtask

  // lock, try a mismatched key while locked, then unlock through a locked confirm
  task automatic test_lock_sequence();
    do_write(ADDR_COMMAND, CMD_LOCK);
    do_write(ADDR_DATA_ONE, LOCK_KEY_LOCK);
    do_write(ADDR_DATA_TWO, LOCK_KEY_LOCK);
    do_write(ADDR_CONFIRM, 8'd0);
    do_write(ADDR_CONFIRM, 8'hFF);
    do_tick(8'd255);
    do_write(ADDR_DATA_TWO, LOCK_KEY_UNLOCK);
    do_write(ADDR_CONFIRM, 8'd0);
    do_tick(8'(DELAY_CONFIRM) + 8'd1);
    do_write(ADDR_DATA_ONE, LOCK_KEY_UNLOCK);
    do_write(ADDR_CONFIRM, 8'd0);
    do_tick(8'(DELAY_CONFIRM) + 8'd1);
  endtask

  // bank wraps to 255, then disable with nmi and reset pulses
  task automatic test_extended_command();
    do_write(ADDR_COMMAND, CMD_EXTENDED);
    do_write(ADDR_DATA_ONE, 8'd0);
    do_write(ADDR_DATA_TWO, 8'b0000_1011);
    do_write(ADDR_CONFIRM, 8'd0);
    do_tick(8'd200);
    do_read(16'd0);
    do_write(ADDR_COMMAND, 8'd1);
  endtask

  task automatic test_simple_command();
    do_button();
    do_write(ADDR_COMMAND, 8'd2);
    do_write(ADDR_COMMAND, 8'd2);
    do_tick(8'(DELAY_48K));
    do_tick(8'd1);
  endtask

  task automatic test_count_wrap();
    logic [7:0] code;
    code = 8'($urandom_range(40, 255));
    repeat (258) do_write(ADDR_COMMAND, code);
    do_read(16'd0);
  endtask

  task automatic test_random_traffic(input int unsigned quota);
    int unsigned stop_at;
    int unsigned pick;
    stop_at = items_sent + quota;
    while (items_sent < stop_at) begin
      pick = $urandom_range(0, 99);
      if ((st_mode == MODE_DISABLED || st_mode == MODE_LOCKED) && pick < 40) begin
        do_button();
      end else if (pick < 35) begin
        send_simple_command(($urandom_range(0, 3) == 0) ? 8'($urandom_range(1, 39)) :
                                                          8'($urandom_range(1, 10)));
      end else if (pick < 65) begin
        send_extended_command();
      end else if (pick < 78) begin
        send_read_burst();
      end else if (pick < 90) begin
        send_noise();
      end else if (pick < 93) begin
        do_button();
      end else if (pick < 95) begin
        drain_results();
      end else begin
        do_tick(8'($urandom));
      end
    end
  endtask

  always @(negedge clk_i) begin
    if (recv_wait != 0) begin
      out_ready_i <= 1'b0;
      recv_wait--;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin : check_results
    rccbc_out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_checked++;
      recv_wait = recv_idle ? $urandom_range(0, 13) : 0;
      if (expected_results.size() == 0) begin
        report_mismatch("result with no transaction waiting for it");
      end else begin
        want = expected_results.pop_front();
        check_field("read_source", out_data_o.read_source, want.read_source);
        check_field("cart_address", out_data_o.cart_address, want.cart_address);
        check_field("cpu_reset", out_data_o.cpu_reset, want.cpu_reset);
        check_field("cpu_nmi", out_data_o.cpu_nmi, want.cpu_nmi);
        check_field("mode", out_data_o.mode, want.mode);
        check_field("active_bank", out_data_o.active_bank, want.active_bank);
      end
    end
  end

  // a stall with no transaction on either side for too long means the block is hung
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("timeout after %0d cycles without a transaction", quiet_cycles);
        $display("rom_cartridge_command_bank_controller_top_test NOT OK");
        $finish;
      end
    end
  end

  initial begin
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    set_machine_48k(1'b1);

    test_before_power_up();
    test_address_window();
    test_lock_sequence();
    test_extended_command();
    test_simple_command();
    test_count_wrap();

    set_machine_48k(1'b0);
    test_random_traffic(300);
    send_idle = 1'b0;
    recv_idle = 1'b0;
    set_machine_48k(1'b1);
    test_random_traffic(250);
    send_idle = 1'b1;
    recv_idle = 1'b1;
    set_machine_48k(1'b0);
    test_random_traffic(120);
    drain_results();

    $display("covered %0d transactions and %0d results, %0d commands executed, both delay settings",
             items_sent, results_checked, commands_run);
    $display("%0d mismatches found", mismatches);
    if (mismatches == 0) begin
      $display("rom_cartridge_command_bank_controller_top_test OK");
    end else begin
      $display("rom_cartridge_command_bank_controller_top_test NOT OK");
    end
    $finish;
  end

endmodule
